/* hw/rtl/arfr_pkg.sv */
// ----------------------------------------------------------------------------
// arfr_pkg
// Shared codes and types for the addressed reply frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package arfr_pkg;

   // action codes carried in req_tuser
   localparam logic [1:0] ACT_ARM  = 2'd0;
   localparam logic [1:0] ACT_BYTE = 2'd1;
   localparam logic [1:0] ACT_TICK = 2'd2;

   // status codes carried in rsp_tuser
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_TIMEOUT = 2'd1;
   localparam logic [1:0] ST_BADSUM  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_LENGTH  = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT = 2'd2;

   localparam logic [7:0]  RST_ADDRESS = 8'd1;
   localparam logic [3:0]  RST_LENGTH  = 4'd3;
   localparam logic [15:0] RST_TIMEOUT = 16'd5;
   localparam logic [15:0] TICK_MAX    = 16'hFFFF;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'b001,
      PH_SEARCH  = 3'b010,
      PH_COLLECT = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0]  address;
      logic [3:0]  length;
      logic [15:0] timeout;
   } cfg_type;

endpackage

`default_nettype wire

/* hw/rtl/arfr_frame.sv */
// ----------------------------------------------------------------------------
// arfr_frame
// Frame search, collection, checksum and timeout state for one receive try.
// ----------------------------------------------------------------------------
`default_nettype none

module arfr_frame #(
   parameter int MaxFrameBytes = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire arfr_pkg::cfg_type    cfg_i,
   input  wire logic                 accept_i,
   input  wire logic [1:0]           action_i,
   input  wire logic [7:0]           rx_byte_i,
   output logic                      res_valid_o,
   output logic [1:0]                res_status_o,
   output logic [((MaxFrameBytes > 2) ? (MaxFrameBytes - 2) * 8 : 8) - 1:0] res_payload_o
);
   import arfr_pkg::*;

   localparam int         PayloadBits = (MaxFrameBytes > 2) ? (MaxFrameBytes - 2) * 8 : 8;
   localparam int         PosBits     = (MaxFrameBytes > 2) ? $clog2(MaxFrameBytes) : 1;
   localparam logic [3:0] MaxLen      = 4'(MaxFrameBytes);

   phase_type              phase_ff, phase_in;
   logic [PosBits-1:0]     pos_ff, pos_in;
   logic [7:0]             sum_ff, sum_in;
   logic [15:0]            ticks_ff, ticks_in;
   logic [PayloadBits-1:0] shift_ff, shift_in;
   logic [3:0]             eff_len;
   logic [3:0]             last_pos;
   logic [15:0]            ticks_inc;

   always_comb begin
      if (cfg_i.length < 4'd2) begin
         eff_len = 4'd2;
      end else if (cfg_i.length > MaxLen) begin
         eff_len = MaxLen;
      end else begin
         eff_len = cfg_i.length;
      end
      last_pos  = eff_len - 4'd1;
      ticks_inc = (ticks_ff == TICK_MAX) ? ticks_ff : ticks_ff + 16'd1;
   end

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      sum_in        = sum_ff;
      ticks_in      = ticks_ff;
      shift_in      = shift_ff;
      res_valid_o   = 1'b0;
      res_status_o  = ST_OK;
      res_payload_o = '0;
      if (accept_i) begin
         case (action_i)
            ACT_ARM: begin
               phase_in = PH_SEARCH;
               pos_in   = '0;
               sum_in   = '0;
               ticks_in = '0;
               shift_in = '0;
            end
            ACT_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  ticks_in = ticks_inc;
                  if (ticks_inc >= cfg_i.timeout) begin
                     res_valid_o  = 1'b1;
                     res_status_o = ST_TIMEOUT;
                     phase_in     = PH_IDLE;
                  end
               end
            end
            ACT_BYTE: begin
               if (phase_ff == PH_SEARCH) begin
                  if (rx_byte_i == cfg_i.address) begin
                     sum_in   = rx_byte_i;
                     pos_in   = PosBits'(1);
                     phase_in = PH_COLLECT;
                  end
               end else if (phase_ff == PH_COLLECT) begin
                  if (4'(pos_ff) >= last_pos) begin
                     res_valid_o = 1'b1;
                     phase_in    = PH_IDLE;
                     if (rx_byte_i == sum_ff) begin
                        res_status_o  = ST_OK;
                        res_payload_o = shift_ff;
                     end else begin
                        res_status_o = ST_BADSUM;
                     end
                  end else begin
                     sum_in   = sum_ff + rx_byte_i;
                     shift_in = (shift_ff << 8) | PayloadBits'(rx_byte_i);
                     pos_in   = pos_ff + PosBits'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         sum_ff   <= '0;
         ticks_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         ticks_ff <= ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/addressed_reply_frame_receiver.sv */
// ----------------------------------------------------------------------------
// addressed_reply_frame_receiver
// Receives one fixed-length addressed reply frame with an additive checksum.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one item per arm, received byte or time tick. req_tuser
//   carries the action, req_tdata the byte. An arm item starts a search for
//   the address byte and clears the tick counter.
//   rsp channel: one item per finished try: rsp_tuser carries the status
//   (ok, timeout, checksum mismatch), rsp_tdata the payload with the first
//   byte most significant (zero on failure).
//   csr port: expected address, frame length and timeout; write only while
//   no item is in flight.
// Timing:
//   Each item is handled in the cycle it is accepted; a result shows on rsp
//   in the cycle after. One item per cycle is accepted while req_tready is
//   high, i.e. while rsp is empty or its result is being taken.
//   While rsp holds an untaken result, req_tready stays low; it rises again
//   in the cycle the result is taken, so the stream keeps full rate.
// Reset:
//   Synchronous. The receiver goes idle, the result register empties and the
//   registers return to address 1, length 3, timeout 5.
// ----------------------------------------------------------------------------
`default_nettype none

module addressed_reply_frame_receiver #(
   parameter int MaxFrameBytes = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic [1:0]  req_tuser,   // [1:0] action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [((MaxFrameBytes > 2) ? (MaxFrameBytes - 2) * 8 : 8) - 1:0] rsp_tdata,
                                         // payload
   output logic [1:0]       rsp_tuser,   // [1:0] status
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import arfr_pkg::*;

   localparam int PayloadBits = (MaxFrameBytes > 2) ? (MaxFrameBytes - 2) * 8 : 8;

   cfg_type                cfg_ff;
   logic                   accept;
   logic                   res_valid;
   logic [1:0]             res_status;
   logic [PayloadBits-1:0] res_payload;
   logic                   valid_ff;
   logic [1:0]             status_ff;
   logic [PayloadBits-1:0] payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.address <= RST_ADDRESS;
         cfg_ff.length  <= RST_LENGTH;
         cfg_ff.timeout <= RST_TIMEOUT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ADDRESS: cfg_ff.address <= csr_wdata[7:0];
            CSR_LENGTH:  cfg_ff.length  <= csr_wdata[3:0];
            CSR_TIMEOUT: cfg_ff.timeout <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_tready = !valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   arfr_frame #(
      .MaxFrameBytes(MaxFrameBytes)
   ) u_frame (
      .clock        (clock),
      .reset        (reset),
      .cfg_i        (cfg_ff),
      .accept_i     (accept),
      .action_i     (req_tuser),
      .rx_byte_i    (req_tdata),
      .res_valid_o  (res_valid),
      .res_status_o (res_status),
      .res_payload_o(res_payload)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && res_valid) begin
         status_ff  <= res_status;
         payload_ff <= res_payload;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = payload_ff;

endmodule

`default_nettype wire

/* hw/rtl/arfr_checker.sv */
// ----------------------------------------------------------------------------
// arfr_checker
// Port-level checks for the addressed reply frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module arfr_checker #(
   parameter int MaxFrameBytes = 8
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [((MaxFrameBytes > 2) ? (MaxFrameBytes - 2) * 8 : 8) - 1:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);
   import arfr_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == '0)
      else $error("nonzero payload on failed frame");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == ST_OK || rsp_tuser == ST_TIMEOUT || rsp_tuser == ST_BADSUM)
      else $error("undefined status on rsp");

   a_arm_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ACT_ARM && !(rsp_tvalid && !rsp_tready)
      |=> !rsp_tvalid)
      else $error("arm item produced a result");

endmodule

bind addressed_reply_frame_receiver arfr_checker #(
   .MaxFrameBytes(MaxFrameBytes)
) u_arfr_checker (.*);

`default_nettype wire

/* tb/sv/addressed_reply_frame_receiver_tb.sv */
// ----------------------------------------------------------------------------
// addressed_reply_frame_receiver_tb
// Self-checking bench for the addressed reply frame receiver. Arm, byte and
// tick items go in on the req stream and a frame scoreboard predicts each
// reply. Replies on rsp are compared field by field, in order. Register
// settings change between runs of traffic, and both streams stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module addressed_reply_frame_receiver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import arfr_pkg::*;

   localparam int         MAX_FRAME_BYTES = 8;
   localparam int         PAYLOAD_BITS    = (MAX_FRAME_BYTES - 2) * 8;
   localparam int         TOTAL_ITEMS     = 1700;
   localparam int         HOLD_CYCLES     = 300;
   localparam logic [1:0] ACT_NONE        = 2'd3;

   typedef struct packed {
      logic [1:0]              status;
      logic [PAYLOAD_BITS-1:0] payload;
   } frame_reply_type;

   class frame_scoreboard;
      logic [7:0]              address;
      logic [3:0]              length;
      logic [15:0]             timeout;
      phase_type               phase;
      logic [2:0]              position;
      logic [7:0]              sum;
      logic [15:0]             ticks;
      logic [PAYLOAD_BITS-1:0] payload;
      frame_reply_type         pending_replies[$];
      int                      mismatches;
      int                      replies_checked;

      function new();
         address         = RST_ADDRESS;
         length          = RST_LENGTH;
         timeout         = RST_TIMEOUT;
         phase           = PH_IDLE;
         mismatches      = 0;
         replies_checked = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         position = '0;
         sum      = '0;
         ticks    = '0;
         payload  = '0;
      endfunction

      function int frame_bytes();
         if (length < 2) return 2;
         if (length > MAX_FRAME_BYTES) return MAX_FRAME_BYTES;
         return int'(length);
      endfunction

      function void finish_frame(logic [1:0] status, logic [PAYLOAD_BITS-1:0] data);
         frame_reply_type reply;
         reply.status  = status;
         reply.payload = data;
         pending_replies.push_back(reply);
         phase = PH_IDLE;
      endfunction

      function void note_config(logic [1:0] index, logic [15:0] value);
         case (index)
            CSR_ADDRESS: address = value[7:0];
            CSR_LENGTH:  length  = value[3:0];
            CSR_TIMEOUT: timeout = value;
            default: ;
         endcase
      endfunction

      function void note_item(logic [1:0] action, logic [7:0] rx);
         if (action == ACT_ARM) begin
            clear_frame();
            phase = PH_SEARCH;
         end else if (phase != PH_IDLE && action == ACT_TICK) begin
            if (ticks != TICK_MAX) ticks++;
            if (ticks >= timeout) finish_frame(ST_TIMEOUT, '0);
         end else if (phase == PH_SEARCH && action == ACT_BYTE) begin
            if (rx == address) begin
               sum      = rx;
               position = 3'd1;
               phase    = PH_COLLECT;
            end
         end else if (phase == PH_COLLECT && action == ACT_BYTE) begin
            if (int'(position) >= frame_bytes() - 1) begin
               if (rx == sum) finish_frame(ST_OK, payload);
               else finish_frame(ST_BADSUM, '0);
            end else begin
               sum      = sum + rx;
               payload  = {payload[PAYLOAD_BITS-9:0], rx};
               position = position + 3'd1;
            end
         end
      endfunction

      function void check_reply(logic [1:0] status, logic [PAYLOAD_BITS-1:0] data);
         frame_reply_type want;
         replies_checked++;
         if (pending_replies.size() == 0) begin
            $error("unexpected reply: status %0d payload %h", status, data);
            mismatches++;
            return;
         end
         want = pending_replies.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatches++;
         end
         if (data !== want.payload) begin
            $error("payload: expected %h, actual %h", want.payload, data);
            mismatches++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [7:0]              req_tdata;   // [7:0] rx_byte
   logic [1:0]              req_tuser;   // [1:0] action
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [PAYLOAD_BITS-1:0] rsp_tdata;   // payload
   logic [1:0]              rsp_tuser;   // [1:0] status
   logic                    csr_we;
   logic [1:0]              csr_index;
   logic [15:0]             csr_wdata;

   frame_scoreboard sb;
   int              items_sent;
   bit              idle_on;
   bit              hold_rsp;

   addressed_reply_frame_receiver #(
      .MaxFrameBytes(MAX_FRAME_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("** addressed_reply_frame_receiver: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_item(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_reply(rsp_tuser, rsp_tdata);
      end
   end

   // receiver side: random stalls, plus one long hold on request
   initial begin
      int stall;
      stall      = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (idle_on && stall == 0 && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 8);
         rsp_tready <= (stall == 0);
         if (stall > 0) stall--;
      end
   end

   // enter and leave at a falling edge; valid stays high for a following item
   task automatic send_item(input logic [1:0] action, input logic [7:0] rx);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input bit good_sum, input int tick_odds);
      logic [7:0] sum;
      logic [7:0] rx;
      sum = sb.address;
      send_item(ACT_BYTE, sb.address);
      repeat (sb.frame_bytes() - 2) begin
         rx  = 8'($urandom);
         sum = sum + rx;
         if (tick_odds != 0 && $urandom_range(1, tick_odds) == 1)
            send_item(ACT_TICK, 8'($urandom));
         send_item(ACT_BYTE, rx);
      end
      send_item(ACT_BYTE, good_sum ? sum : sum + 8'($urandom_range(1, 255)));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending_replies.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      sb.note_config(index, value);
      @(negedge clock);
   endtask

   task automatic write_settings(input logic [7:0] address, input logic [3:0] length,
                                 input logic [15:0] timeout);
      write_csr(CSR_ADDRESS, {8'd0, address});
      write_csr(CSR_LENGTH, {12'd0, length});
      write_csr(CSR_TIMEOUT, timeout);
      csr_we <= 1'b0;
   endtask

   initial begin
      int pick;
      int phase_no;
      int phase_end;
      sb         = new();
      items_sent = 0;
      idle_on    = 1'b1;
      hold_rsp   = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ACT_ARM;
      csr_we     = 1'b0;
      csr_index  = CSR_ADDRESS;
      csr_wdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // idle: drop bytes, ticks and the unused action
      send_item(ACT_BYTE, 8'h01);
      send_item(ACT_TICK, 8'hFF);
      send_item(ACT_NONE, 8'h00);
      // good frame behind a dropped lead byte
      send_item(ACT_ARM, 8'h00);
      send_item(ACT_BYTE, 8'h55);
      send_item(ACT_BYTE, 8'h01);
      send_item(ACT_BYTE, 8'hFF);
      send_item(ACT_BYTE, 8'h00);
      // checksum mismatch
      send_item(ACT_ARM, 8'hFF);
      send_item(ACT_BYTE, 8'h01);
      send_item(ACT_BYTE, 8'h10);
      send_item(ACT_BYTE, 8'h00);
      // timeout, unused action in between
      send_item(ACT_ARM, 8'h00);
      send_item(ACT_TICK, 8'h00);
      send_item(ACT_TICK, 8'h00);
      send_item(ACT_NONE, 8'hFF);
      repeat (3) send_item(ACT_TICK, 8'h00);
      // re-arm in the middle of a frame
      send_item(ACT_ARM, 8'h00);
      send_item(ACT_BYTE, 8'h01);
      send_item(ACT_ARM, 8'h00);
      send_item(ACT_BYTE, 8'h01);
      send_item(ACT_BYTE, 8'h02);
      send_item(ACT_BYTE, 8'h03);

      // zero timeout, longest frame
      wait_drained();
      write_settings(8'hFF, 4'd8, 16'd0);
      send_item(ACT_ARM, 8'h00);
      send_item(ACT_TICK, 8'h00);
      send_item(ACT_ARM, 8'h00);
      send_frame(1'b1, 0);
      // length below range acts as shortest frame
      wait_drained();
      write_settings(8'h00, 4'd0, 16'hFFFF);
      send_item(ACT_ARM, 8'h00);
      send_frame(1'b1, 0);
      // length above range, then shortened mid-frame: next byte is the checksum
      wait_drained();
      write_settings(8'h00, 4'd15, 16'hFFFF);
      send_item(ACT_ARM, 8'h00);
      send_item(ACT_BYTE, 8'h00);
      send_item(ACT_BYTE, 8'h80);
      send_item(ACT_BYTE, 8'h7F);
      wait_drained();
      write_settings(8'h00, 4'd3, 16'hFFFF);
      send_item(ACT_BYTE, 8'hFF);

      phase_no = 0;
      while (items_sent < TOTAL_ITEMS || sb.replies_checked < 60) begin
         wait_drained();
         idle_on = (items_sent < TOTAL_ITEMS - 300);
         case (phase_no)
            0: write_settings(8'h00, 4'd2, 16'd1);
            1: write_settings(8'hFF, 4'd8, 16'hFFFF);
            default: write_settings(8'($urandom), 4'($urandom),
                                    ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                : 16'($urandom_range(0, 30)));
         endcase
         if (phase_no == 2) hold_rsp = 1'b1;
         phase_end = items_sent + 150;
         while (items_sent < phase_end) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
               send_item(ACT_ARM, 8'($urandom));
               repeat ($urandom_range(0, 2)) send_item(ACT_BYTE, 8'($urandom));
               send_frame($urandom_range(0, 3) != 0, 8);
            end else if (pick == 6) begin
               send_item(ACT_ARM, 8'($urandom));
               repeat ($urandom_range(1, 40)) send_item(ACT_TICK, 8'($urandom));
            end else if (pick == 7) begin
               repeat (8) send_item(2'($urandom), 8'($urandom));
            end else begin
               send_item(ACT_ARM, 8'($urandom));
               send_item(ACT_BYTE, sb.address);
               send_item(ACT_BYTE, 8'($urandom));
            end
         end
         phase_no++;
      end

      wait_drained();
      repeat (8) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
         $display("** addressed_reply_frame_receiver: PASSED **");
      end else begin
         $display("** addressed_reply_frame_receiver: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* addressed_reply_frame_receiver.f */
hw/rtl/arfr_pkg.sv
hw/rtl/arfr_frame.sv
hw/rtl/addressed_reply_frame_receiver.sv
hw/rtl/arfr_checker.sv
tb/sv/addressed_reply_frame_receiver_tb.sv
